// File: hw/rtl/lwtd_pkg.sv
`timescale 1ns / 1ps

package lwtd_pkg;

  // window geometry
  localparam int WINDOW_LEN = 5;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int VCPU_W     = 7;
  localparam int FACTOR_W   = 10;
  localparam int NEEDED_W   = 5;
  localparam int COUNT_W    = 5;
  localparam int VERDICT_W  = 2;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // register reset values
  localparam logic                  RST_DETECT_MODE = 1'b1;
  localparam logic [VCPU_W-1:0]     RST_VCPU_COUNT  = 7'd1;
  localparam logic [SAMPLE_W-1:0]   RST_HIGH_LEVEL  = 16'd179;
  localparam logic [SAMPLE_W-1:0]   RST_LOW_LEVEL   = 16'd8;
  localparam logic [FACTOR_W-1:0]   RST_RISE_FACTOR = 10'd269;
  localparam logic [FACTOR_W-1:0]   RST_FALL_FACTOR = 10'd243;
  localparam logic [NEEDED_W-1:0]   RST_HIGH_NEEDED = 5'd2;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NORMAL = 2'd0,
    VERDICT_HIGH   = 2'd1,
    VERDICT_LOW    = 2'd2
  } verdict_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DETECT_MODE = 3'd0,
    REG_VCPU_COUNT  = 3'd1,
    REG_HIGH_LEVEL  = 3'd2,
    REG_LOW_LEVEL   = 3'd3,
    REG_RISE_FACTOR = 3'd4,
    REG_FALL_FACTOR = 3'd5,
    REG_HIGH_NEEDED = 3'd6
  } reg_idx_t;

  // detect modes
  localparam logic MODE_TREND = 1'b0;
  localparam logic MODE_K_OF_N = 1'b1;

  typedef struct packed {
    logic                detect_mode;
    logic [VCPU_W-1:0]   vcpu_count;
    logic [SAMPLE_W-1:0] high_level;
    logic [SAMPLE_W-1:0] low_level;
    logic [FACTOR_W-1:0] rise_factor;
    logic [FACTOR_W-1:0] fall_factor;
    logic [NEEDED_W-1:0] high_needed;
  } cfg_t;

  function automatic logic [COUNT_W-1:0] count_ones(input logic [WINDOW_LEN-1:0] flags);
    logic [COUNT_W-1:0] total;
    total = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      total = total + COUNT_W'(flags[i]);
    end
    return total;
  endfunction

endpackage

// File: hw/rtl/load_window_threshold_detector_core.sv
`timescale 1ns / 1ps

// channel   dir  tdata bits (lowest first)                     tuser/tlast
// s_*       in   usage_sample[15:0]                            none
// m_*       out  verdict[1:0], hit_count[6:2], window_full[7]  none
// cfg_*     in   cfg_index selects register, cfg_data[15:0]    write only
//
// one item per cycle while m_* is not stalled; each result appears in the cycle after its item
// is taken, set by the single output register behind the cell row
// s_tready stays high while the output register is empty or being drained,
// so a stall on m_* holds at most one finished item
// synchronous reset clears the window cells, fill counter and registers to
// their defaults; no clearing pass, items are taken from the first cycle on
module load_window_threshold_detector_core (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lwtd_pkg::IN_DATA_W-1:0]    s_tdata,   // usage_sample
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lwtd_pkg::OUT_DATA_W-1:0]   m_tdata,   // verdict, hit_count, window_full
  // register writes
  input  logic                              cfg_we,
  input  logic [lwtd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [lwtd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int N = lwtd_pkg::WINDOW_LEN;

  lwtd_pkg::cfg_t                  cfg;
  logic [lwtd_pkg::FILL_W-1:0]     fill_count;
  logic [lwtd_pkg::FILL_W-1:0]     fill_count_next;
  logic                            accept;
  logic                            full;

  logic [lwtd_pkg::SAMPLE_W-1:0]   slot    [N];
  logic [lwtd_pkg::SAMPLE_W-1:0]   chain_in[N];
  logic [N-1:0]                    at_high;

  lwtd_pkg::verdict_t              trend_verdict;
  lwtd_pkg::verdict_t              verdict_next;
  logic [lwtd_pkg::COUNT_W-1:0]    hit_count;
  logic [lwtd_pkg::COUNT_W-1:0]    count_next;

  lwtd_pkg::verdict_t              verdict;
  logic [lwtd_pkg::COUNT_W-1:0]    count_out;
  logic                            window_full;

  // register file; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_mode <= lwtd_pkg::RST_DETECT_MODE;
      cfg.vcpu_count  <= lwtd_pkg::RST_VCPU_COUNT;
      cfg.high_level  <= lwtd_pkg::RST_HIGH_LEVEL;
      cfg.low_level   <= lwtd_pkg::RST_LOW_LEVEL;
      cfg.rise_factor <= lwtd_pkg::RST_RISE_FACTOR;
      cfg.fall_factor <= lwtd_pkg::RST_FALL_FACTOR;
      cfg.high_needed <= lwtd_pkg::RST_HIGH_NEEDED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lwtd_pkg::REG_DETECT_MODE: cfg.detect_mode <= cfg_data[0];
        lwtd_pkg::REG_VCPU_COUNT:  cfg.vcpu_count  <= cfg_data[lwtd_pkg::VCPU_W-1:0];
        lwtd_pkg::REG_HIGH_LEVEL:  cfg.high_level  <= cfg_data[lwtd_pkg::SAMPLE_W-1:0];
        lwtd_pkg::REG_LOW_LEVEL:   cfg.low_level   <= cfg_data[lwtd_pkg::SAMPLE_W-1:0];
        lwtd_pkg::REG_RISE_FACTOR: cfg.rise_factor <= cfg_data[lwtd_pkg::FACTOR_W-1:0];
        lwtd_pkg::REG_FALL_FACTOR: cfg.fall_factor <= cfg_data[lwtd_pkg::FACTOR_W-1:0];
        lwtd_pkg::REG_HIGH_NEEDED: cfg.high_needed <= cfg_data[lwtd_pkg::NEEDED_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (fill_count == lwtd_pkg::FILL_W'(N));

  // filling slot by slot from a zeroed window ends with the same contents as
  // shifting in, so the row always shifts; slot 0 holds the oldest sample
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      assign chain_in[i] = s_tdata[lwtd_pkg::SAMPLE_W-1:0];
    end else begin : g_mid
      assign chain_in[i] = slot[i + 1];
    end

    lwtd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (accept),
      .data_in    (chain_in[i]),
      .high_level (cfg.high_level),
      .sample     (slot[i]),
      .at_high    (at_high[i])
    );
  end

  lwtd_trend u_trend (
    .cfg     (cfg),
    .sample  (s_tdata[lwtd_pkg::SAMPLE_W-1:0]),
    .oldest  (slot[0]),
    .verdict (trend_verdict)
  );

  // count over the window as it stands after the shift
  assign hit_count = lwtd_pkg::count_ones(at_high);

  always_comb begin
    verdict_next = lwtd_pkg::VERDICT_NORMAL;
    count_next   = '0;
    if (full) begin
      if (cfg.detect_mode == lwtd_pkg::MODE_TREND) begin
        verdict_next = trend_verdict;
      end else begin
        count_next = hit_count;
        if (hit_count >= cfg.high_needed) begin
          verdict_next = lwtd_pkg::VERDICT_HIGH;
        end
      end
    end
  end

  // fill counter saturates at the window length
  assign fill_count_next = full ? fill_count : fill_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      verdict     <= verdict_next;
      count_out   <= count_next;
      window_full <= (fill_count_next == lwtd_pkg::FILL_W'(N));
    end
  end

  assign m_tdata = {window_full, count_out, verdict};

  // fill counter never runs past the window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= lwtd_pkg::FILL_W'(N))
    else $error("fill counter beyond window length");

  // a result before the window is full is always normal with no count
  a_fill_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !window_full |->
      verdict == lwtd_pkg::VERDICT_NORMAL && count_out == '0)
    else $error("non-normal result while window filling");

  // a low verdict only comes from the trend check, which reports no count
  a_low_no_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && verdict == lwtd_pkg::VERDICT_LOW |-> count_out == '0)
    else $error("low verdict with a nonzero hit count");

  // every taken item leaves a result in the output register
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item produced no result");

endmodule

// File: hw/rtl/lwtd_cell.sv
`timescale 1ns / 1ps

// one window slot: takes its neighbour's sample, or the new sample at the tail, on every accepted item
module lwtd_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift_en,
  input  logic [lwtd_pkg::SAMPLE_W-1:0]  data_in,
  input  logic [lwtd_pkg::SAMPLE_W-1:0]  high_level,
  output logic [lwtd_pkg::SAMPLE_W-1:0]  sample,
  output logic                           at_high
);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (shift_en) begin
      sample <= data_in;
    end
  end

  // flag for the value this slot holds once the shift is done
  assign at_high = (data_in >= high_level);

endmodule

// File: hw/rtl/lwtd_trend.sv
`timescale 1ns / 1ps

// trend check of a new sample against scaled levels and the oldest sample
module lwtd_trend (
  input  lwtd_pkg::cfg_t                 cfg,
  input  logic [lwtd_pkg::SAMPLE_W-1:0]  sample,
  input  logic [lwtd_pkg::SAMPLE_W-1:0]  oldest,
  output lwtd_pkg::verdict_t             verdict
);

  localparam int THR_W  = lwtd_pkg::VCPU_W + lwtd_pkg::SAMPLE_W;
  localparam int PROD_W = lwtd_pkg::SAMPLE_W + lwtd_pkg::FACTOR_W;

  logic [THR_W-1:0]  hi_thr;
  logic [THR_W-1:0]  lo_thr;
  logic [PROD_W-1:0] rise_prod;
  logic [PROD_W-1:0] fall_prod;
  logic [PROD_W-1:0] sample_q16;
  logic [THR_W-1:0]  sample_ext;

  assign hi_thr     = THR_W'(cfg.vcpu_count) * THR_W'(cfg.high_level);
  assign lo_thr     = THR_W'(cfg.vcpu_count) * THR_W'(cfg.low_level);
  assign rise_prod  = PROD_W'(oldest) * PROD_W'(cfg.rise_factor);
  assign fall_prod  = PROD_W'(oldest) * PROD_W'(cfg.fall_factor);
  assign sample_q16 = PROD_W'({sample, 8'h00});
  assign sample_ext = THR_W'(sample);

  always_comb begin
    priority if (sample_ext > hi_thr && sample_q16 > rise_prod) begin
      verdict = lwtd_pkg::VERDICT_HIGH;
    end else if (sample_ext < lo_thr && sample_q16 < fall_prod) begin
      verdict = lwtd_pkg::VERDICT_LOW;
    end else begin
      verdict = lwtd_pkg::VERDICT_NORMAL;
    end
  end

endmodule
